// ----- rtl/acdio_pkg.sv -----
`timescale 1ns / 1ps

package acdio_pkg;

    typedef enum logic [2:0] {
        CMD_CTRL_WRITE = 3'd0,
        CMD_READ_PORT0 = 3'd1,
        CMD_READ_PORT1 = 3'd2,
        CMD_PROT_READ  = 3'd3,
        CMD_SOFT_RESET = 3'd4
    } t_cmd;

    localparam logic [2:0] REG_BLOCK_ENABLED = 3'd0;
    localparam logic [2:0] REG_DUAL_MODE     = 3'd1;
    localparam logic [2:0] REG_BOARD_VARIANT = 3'd2;
    localparam logic [2:0] REG_INPUT_WIRING  = 3'd3;
    localparam logic [2:0] REG_DIP_SWITCHES  = 3'd4;

    localparam logic [2:0] VARIANT_TABLE_A     = 3'd1;
    localparam logic [2:0] VARIANT_TABLE_B     = 3'd2;
    localparam logic [2:0] VARIANT_TABLE_C     = 3'd3;
    localparam logic [2:0] VARIANT_START_FORCE = 3'd4;

    localparam logic [1:0] WIRING_PAD_SWAP = 2'd1;
    localparam logic [1:0] WIRING_AB_CROSS = 2'd2;

    localparam logic [15:0] ADDR_LO_HANDLED = 16'h4020;
    localparam logic [15:0] ADDR_HI_HANDLED = 16'h5FFF;
    localparam logic [15:0] ADDR_PROT_CLEAR = 16'h5E00;
    localparam logic [15:0] ADDR_PROT_READ  = 16'h5E01;

    localparam logic [7:0] SYS_BUTTONS = 8'h0C;

    typedef struct packed {
        logic        enabled;
        logic        dual;
        logic [2:0]  variant;
        logic [1:0]  wiring;
        logic [15:0] dips;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  command;
        logic        side;
        logic [7:0]  write_value;
        logic [15:0] address;
        logic [7:0]  pad_first;
        logic [7:0]  pad_second;
        logic        coin_first;
        logic        coin_second;
        logic        service_pressed;
    } t_item;

    typedef struct packed {
        logic       irq_pending;
        logic       ram_allowed;
        logic       bank_select;
        logic       handled;
        logic [7:0] read_data;
    } t_result;

    function automatic logic [7:0] prot_table_a(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:  v = 8'hFF;  5'd1:  v = 8'hBF;  5'd2:  v = 8'hB7;  5'd3:  v = 8'h97;
            5'd4:  v = 8'h97;  5'd5:  v = 8'h17;  5'd6:  v = 8'h57;  5'd7:  v = 8'h4F;
            5'd8:  v = 8'h6F;  5'd9:  v = 8'h6B;  5'd10: v = 8'hEB;  5'd11: v = 8'hA9;
            5'd12: v = 8'hB1;  5'd13: v = 8'h90;  5'd14: v = 8'h94;  5'd15: v = 8'h14;
            5'd16: v = 8'h56;  5'd17: v = 8'h4E;  5'd18: v = 8'h6F;  5'd19: v = 8'h6B;
            5'd20: v = 8'hEB;  5'd21: v = 8'hA9;  5'd22: v = 8'hB1;  5'd23: v = 8'h90;
            5'd24: v = 8'hD4;  5'd25: v = 8'h5C;  5'd26: v = 8'h3E;  5'd27: v = 8'h26;
            5'd28: v = 8'h87;  5'd29: v = 8'h83;  5'd30: v = 8'h13;  default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] prot_table_b(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd4:    v = 8'hB4;
            5'd9:    v = 8'h6F;
            5'd14:   v = 8'h94;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] prot_table_c(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:    v = 8'h05;
            5'd1:    v = 8'h01;
            5'd2:    v = 8'h89;
            5'd3:    v = 8'h37;
            5'd4:    v = 8'h05;
            5'd6:    v = 8'hD1;
            5'd7:    v = 8'h3E;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/acdio_remap.sv -----
`timescale 1ns / 1ps

module acdio_remap
    import acdio_pkg::*;
(
    input  logic [7:0] i_pad_first,
    input  logic [7:0] i_pad_second,
    input  logic [1:0] i_wiring,
    input  logic [2:0] i_variant,
    output logic [7:0] o_pad_first,
    output logic [7:0] o_pad_second
);

    logic [7:0] wired_a;
    logic [7:0] wired_b;

    always_comb begin
        wired_a = i_pad_first;
        wired_b = i_pad_second;
        case (i_wiring)
            WIRING_PAD_SWAP: begin
                wired_a = (i_pad_second & ~SYS_BUTTONS) | (i_pad_first & SYS_BUTTONS);
                wired_b = (i_pad_first & ~SYS_BUTTONS) | (i_pad_second & SYS_BUTTONS);
            end
            WIRING_AB_CROSS: begin
                wired_a[1] = i_pad_second[0];
                wired_b[0] = i_pad_first[1];
            end
            default: begin
            end
        endcase
    end

    // Select and start trade places on both pads; one board forces start on.
    always_comb begin
        o_pad_first  = {wired_a[7:4], wired_a[2], wired_a[3], wired_a[1:0]};
        o_pad_second = {wired_b[7:4], wired_b[2], wired_b[3], wired_b[1:0]};
        if (i_variant == VARIANT_START_FORCE) begin
            o_pad_first[3]  = 1'b1;
            o_pad_second[3] = 1'b1;
        end
    end

endmodule

// ----- rtl/acdio_core.sv -----
`timescale 1ns / 1ps

module acdio_core
    import acdio_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [1:0] r_strobe;
    logic [1:0] n_strobe;
    logic [7:0] r_shift [4];
    logic [7:0] n_shift [4];
    logic [1:0] r_bank;
    logic [1:0] n_bank;
    logic       r_owner;
    logic       n_owner;
    logic [1:0] r_irq;
    logic [1:0] n_irq;
    logic [4:0] r_prot_idx [2];
    logic [4:0] n_prot_idx [2];

    logic       sd;
    logic       port;
    logic [1:0] slot;
    logic [7:0] pads [2];
    logic [7:0] dips;
    logic       bit_out;
    logic       in_range;
    logic [4:0] idx;

    assign sd   = i_cfg.dual & i_item.side;
    assign port = (i_item.command == CMD_READ_PORT1);
    assign slot = {sd, port};
    assign dips = sd ? i_cfg.dips[15:8] : i_cfg.dips[7:0];
    assign idx  = r_prot_idx[sd];
    assign in_range = (i_item.address >= ADDR_LO_HANDLED)
                   && (i_item.address <= ADDR_HI_HANDLED);

    acdio_remap u_remap (
        .i_pad_first  (i_item.pad_first),
        .i_pad_second (i_item.pad_second),
        .i_wiring     (i_cfg.wiring),
        .i_variant    (i_cfg.variant),
        .o_pad_first  (pads[0]),
        .o_pad_second (pads[1])
    );

    always_comb begin
        n_strobe   = r_strobe;
        n_shift    = r_shift;
        n_bank     = r_bank;
        n_owner    = r_owner;
        n_irq      = r_irq;
        n_prot_idx = r_prot_idx;
        bit_out    = r_strobe[sd] ? pads[port][0] : r_shift[slot][0];
        o_result   = '0;
        if (i_cfg.enabled) begin
            unique case (i_item.command)
                CMD_CTRL_WRITE: begin
                    if (r_strobe[sd] && !i_item.write_value[0]) begin
                        n_shift[{sd, 1'b0}] = pads[0];
                        n_shift[{sd, 1'b1}] = pads[1];
                    end
                    n_strobe[sd] = i_item.write_value[0];
                    n_bank[sd]   = i_item.write_value[2];
                    if (i_cfg.dual) begin
                        if (!sd) begin
                            n_owner = ~i_item.write_value[1];
                        end
                        n_irq[~sd] = ~i_item.write_value[1];
                    end
                end
                CMD_READ_PORT0, CMD_READ_PORT1: begin
                    if (!r_strobe[sd]) begin
                        n_shift[slot] = {1'b1, r_shift[slot][7:1]};
                    end
                    if (!port) begin
                        o_result.read_data = {sd, i_item.coin_second, i_item.coin_first,
                                              dips[1:0], i_item.service_pressed,
                                              1'b0, bit_out};
                    end else begin
                        o_result.read_data = {dips[7:2], 1'b0, bit_out};
                    end
                end
                CMD_PROT_READ: begin
                    if (in_range) begin
                        o_result.handled = 1'b1;
                        if (i_item.address == ADDR_PROT_CLEAR) begin
                            n_prot_idx[sd] = '0;
                        end else if (i_item.address == ADDR_PROT_READ) begin
                            if (i_cfg.variant == VARIANT_TABLE_A) begin
                                o_result.read_data = prot_table_a(idx);
                                n_prot_idx[sd] = idx + 5'd1;
                            end else if (i_cfg.variant == VARIANT_TABLE_B) begin
                                o_result.read_data = prot_table_b(idx);
                                n_prot_idx[sd] = idx + 5'd1;
                            end
                        end else if (i_cfg.variant == VARIANT_TABLE_C) begin
                            o_result.read_data = prot_table_c(idx);
                            n_prot_idx[sd] = idx + 5'd1;
                        end
                    end
                end
                CMD_SOFT_RESET: begin
                    n_prot_idx[0] = '0;
                    n_prot_idx[1] = '0;
                    n_owner       = i_cfg.dual;
                    n_irq         = {i_cfg.dual, 1'b0};
                end
                default: begin
                end
            endcase
        end
        o_result.bank_select = i_cfg.enabled & n_bank[sd];
        o_result.ram_allowed = !(i_cfg.enabled && i_cfg.dual) || (sd == n_owner);
        o_result.irq_pending = i_cfg.enabled & i_cfg.dual & n_irq[sd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe      <= '0;
            r_shift       <= '{default: '0};
            r_bank        <= '0;
            r_owner       <= 1'b0;
            r_irq         <= '0;
            r_prot_idx    <= '{default: '0};
        end else if (i_step) begin
            r_strobe      <= n_strobe;
            r_shift       <= n_shift;
            r_bank        <= n_bank;
            r_owner       <= n_owner;
            r_irq         <= n_irq;
            r_prot_idx    <= n_prot_idx;
        end
    end

    a_prot_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_prot_idx[0]) && $stable(r_prot_idx[1])))
        else $error("protection index changed without a beat");

    a_soft_reset_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_cfg.enabled && i_item.command == CMD_SOFT_RESET)
        |=> (r_owner == $past(i_cfg.dual) && !r_irq[0]
             && r_prot_idx[0] == 5'd0 && r_prot_idx[1] == 5'd0))
        else $error("soft reset left wrong shared state");

    a_handled_only_prot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.handled |-> (i_cfg.enabled && i_item.command == CMD_PROT_READ))
        else $error("handled flag outside an enabled protection read");

    a_irq_needs_dual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.irq_pending |-> (i_cfg.dual && i_cfg.enabled))
        else $error("interrupt reported outside dual mode");

endmodule

// ----- rtl/arcade_dual_console_io_block.sv -----
`timescale 1ns / 1ps
// A result beat passes through the input register, then the result register.
// Throughput: one beat per cycle; the input side keeps accepting while a
// result waits, stalling only when both registers hold data and m_axis_tready is low.
// Reset (synchronous, active low) clears configuration, all side state and both valids.

module arcade_dual_console_io_block
    import acdio_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // side, write_value[7:0], address[15:0], pad_first[7:0], pad_second[7:0],
    // coin_first, coin_second, service_pressed, zero fill
    input  logic [47:0] s_axis_tdata,
    // command[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], handled, bank_select, ram_allowed, irq_pending, zero fill
    output logic [15:0] m_axis_tdata
);

    t_cfg    r_cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_result;
    logic    r_out_valid;
    t_result core_result;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_result};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BLOCK_ENABLED: r_cfg.enabled <= i_cfg_data[0];
                REG_DUAL_MODE:     r_cfg.dual    <= i_cfg_data[0];
                REG_BOARD_VARIANT: r_cfg.variant <= i_cfg_data[2:0];
                REG_INPUT_WIRING:  r_cfg.wiring  <= i_cfg_data[1:0];
                REG_DIP_SWITCHES:  r_cfg.dips    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= {s_axis_tuser, s_axis_tdata[0], s_axis_tdata[8:1], s_axis_tdata[24:9],
                       s_axis_tdata[32:25], s_axis_tdata[40:33], s_axis_tdata[41],
                       s_axis_tdata[42], s_axis_tdata[43]};
        end
        if (advance) begin
            r_result <= core_result;
        end
    end

    acdio_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

endmodule
